### design/wrrqs_pkg.sv
// Shared constants, types and helpers of the weighted round-robin quota scheduler.
`default_nettype none
package wrrqs_pkg;

   localparam int NUM_PORTS  = 8;
   localparam int PORT_W     = 3;
   localparam int COUNT_W    = 8;
   localparam int QUOTA_REGS = 8;
   localparam int QUOTA_W    = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int MASK_W     = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [QUOTA_W-1:0] QUOTA_RESET = QUOTA_W'(1);
   localparam logic [PORT_W-1:0]  LAST_PORT   = PORT_W'(NUM_PORTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the mask and start a scan at the current port
      logic step;    // move the scan to the next port
      logic finish;  // commit the grant decision and fill the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;     // the port under the scan is ready
      logic last;    // the scan is at its final port
   } status_type;

   function automatic logic [PORT_W-1:0] next_port(input logic [PORT_W-1:0] p);
      logic [PORT_W-1:0] n;
      begin
         if (p == LAST_PORT) begin
            n = '0;
         end else begin
            n = p + PORT_W'(1);
         end
         return n;
      end
   endfunction

endpackage
`default_nettype wire

### design/wrrqs_ctrl.sv
// Controller state machine that sequences the port scan and owns the output valid.
`default_nettype none
module wrrqs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire wrrqs_pkg::status_type  status,
   output wrrqs_pkg::cmd_type          cmd
);
   import wrrqs_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;
   logic      done;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign done       = (state_ff == ST_SCAN) && (status.hit || status.last) && out_free;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      cmd.load   = req_tvalid && req_tready;
      cmd.finish = done;
      cmd.step   = (state_ff == ST_SCAN) && !status.hit && !status.last;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (done) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

### design/wrrqs_datapath.sv
// Datapath: quota registers, scan pointer, served count and the output register.
`default_nettype none
module wrrqs_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [wrrqs_pkg::MASK_W-1:0]         req_mask,
   input  wire logic                                 csr_write,
   input  wire logic [wrrqs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [wrrqs_pkg::QUOTA_W-1:0]        csr_data,
   input  wire wrrqs_pkg::cmd_type                   cmd,
   output wrrqs_pkg::status_type                     status,
   output logic                                      out_granted,
   output logic [wrrqs_pkg::PORT_W-1:0]              out_port
);
   import wrrqs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] QUOTA_LIMIT = CSR_IDX_W'(QUOTA_REGS);

   logic [QUOTA_W-1:0] quota_ff [QUOTA_REGS];
   logic [MASK_W-1:0]  mask_ff;
   logic [PORT_W-1:0]  scan_port_ff, scan_port_in;
   logic [PORT_W-1:0]  step_ff, step_in;
   logic               passed_ff, passed_in;
   logic [PORT_W-1:0]  current_port_ff, current_port_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               out_granted_ff;
   logic [PORT_W-1:0]  out_port_ff;

   logic [COUNT_W-1:0] base_count;
   logic [COUNT_W-1:0] inc_count;
   logic [QUOTA_W-1:0] scan_quota;

   assign status.hit  = mask_ff[scan_port_ff];
   assign status.last = (step_ff == LAST_PORT);

   // A port passed over while empty clears the run, so the count restarts.
   assign base_count = passed_ff ? '0 : count_ff;
   assign inc_count  = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + COUNT_W'(1);
   assign scan_quota = quota_ff[scan_port_ff];

   always_comb begin
      scan_port_in    = scan_port_ff;
      step_in         = step_ff;
      passed_in       = passed_ff;
      current_port_in = current_port_ff;
      count_in        = count_ff;
      if (cmd.load) begin
         scan_port_in = current_port_ff;
         step_in      = '0;
         passed_in    = 1'b0;
      end else if (cmd.step) begin
         scan_port_in = next_port(scan_port_ff);
         step_in      = step_ff + PORT_W'(1);
         passed_in    = 1'b1;
      end else if (cmd.finish) begin
         if (status.hit) begin
            if (inc_count == scan_quota) begin
               current_port_in = next_port(scan_port_ff);
               count_in        = '0;
            end else begin
               current_port_in = scan_port_ff;
               count_in        = inc_count;
            end
         end else begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUOTA_REGS; k++) begin
            quota_ff[k] <= QUOTA_RESET;
         end
         current_port_ff <= '0;
         count_ff        <= '0;
         scan_port_ff    <= '0;
         step_ff         <= '0;
         passed_ff       <= 1'b0;
      end else begin
         if (csr_write && (csr_index < QUOTA_LIMIT)) begin
            quota_ff[csr_index[PORT_W-1:0]] <= csr_data;
         end
         current_port_ff <= current_port_in;
         count_ff        <= count_in;
         scan_port_ff    <= scan_port_in;
         step_ff         <= step_in;
         passed_ff       <= passed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mask_ff <= req_mask;
      end
      if (cmd.finish) begin
         out_granted_ff <= status.hit;
         out_port_ff    <= status.hit ? scan_port_ff : '0;
      end
   end

   assign out_granted = out_granted_ff;
   assign out_port    = out_port_ff;

endmodule
`default_nettype wire

### design/weighted_round_robin_quota_scheduler.sv
// The mask is captured when a transaction is accepted; the scan then visits one port per
// cycle (up to 8), and the result is registered once it reaches a ready port or its last
// port while the output register is free. No new request is taken while a scan runs.
// The result sits in an output register, so a new request is taken while it waits.
// Reset (synchronous, active high) sets every quota to 1, the pointer to port 0 and
// the served count to 0; no clearing pass is needed.
`default_nettype none
module weighted_round_robin_quota_scheduler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request side: tdata[7:0] = ready_mask.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,
   // Response side: tdata[2:0] = grant_port, tdata[7:3] = zero.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [7:0]                             rsp_tdata,
   // Response tuser[0] = granted.
   output logic                                   rsp_tuser,
   // Configuration write channel; index i below 8 selects quota register i, others are ignored.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [wrrqs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [wrrqs_pkg::QUOTA_W-1:0]     csr_data
);
   import wrrqs_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic              out_granted;
   logic [PORT_W-1:0] out_port;

   // Quota writes are taken in any cycle; the user is to issue them only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   wrrqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The scan visits the ports one per cycle starting at the remembered port;
   // the first ready port wins and the quota decides whether the pointer moves.
   wrrqs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_mask    (req_tdata),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .out_granted (out_granted),
      .out_port    (out_port)
   );

   assign rsp_tdata = {(8 - PORT_W)'(0), out_port};
   assign rsp_tuser = out_granted;

endmodule
`default_nettype wire
